// ===== rtl/lsms_pkg.sv =====
// ----------------------------------------------------------------------------
// lsms_pkg: shared types and constants of the light sensor measure sequencer
// Request and result structs, status, state and command codes, bus mapping.
// ----------------------------------------------------------------------------
package lsms_pkg;

    localparam int TIME_BITS = 32;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;
    localparam logic [1:0] REQ_TAKE  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_ERROR   = 3'd2;
    localparam logic [2:0] ST_NULL    = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_BUS     = 3'd5;
    localparam logic [2:0] ST_INVALID = 3'd6;

    // bus result codes
    localparam logic [2:0] BR_OK      = 3'd0;
    localparam logic [2:0] BR_NULL    = 3'd1;
    localparam logic [2:0] BR_BUSY    = 3'd2;
    localparam logic [2:0] BR_TIMEOUT = 3'd3;
    localparam logic [2:0] BR_LOCK    = 3'd4;

    // machine states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_STARTING  = 3'd1;
    localparam logic [2:0] S_WAITING   = 3'd2;
    localparam logic [2:0] S_READING   = 3'd3;
    localparam logic [2:0] S_READY     = 3'd4;
    localparam logic [2:0] S_RESETTING = 3'd5;
    localparam logic [2:0] S_ERROR     = 3'd6;

    // sensor commands
    localparam logic [7:0] CMD_POWER_ON   = 8'h01;
    localparam logic [7:0] CMD_RESET      = 8'h07;
    localparam logic [7:0] CMD_ONCE_HIGH  = 8'h20;
    localparam logic [7:0] CMD_ONCE_HIGH2 = 8'h21;
    localparam logic [7:0] CMD_ONCE_LOW   = 8'h23;

    // resolution modes
    localparam logic [1:0] RES_LOW   = 2'd0;
    localparam logic [1:0] RES_HIGH2 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RES_MODE  = 2'd0;
    localparam logic [1:0] CFG_BUS_ADDR  = 2'd1;
    localparam logic [1:0] CFG_LOW_WAIT  = 2'd2;
    localparam logic [1:0] CFG_HIGH_WAIT = 2'd3;

    localparam logic [1:0]  RESET_RES_MODE  = 2'd1;
    localparam logic [6:0]  RESET_BUS_ADDR  = 7'd35;
    localparam logic [15:0] RESET_LOW_WAIT  = 16'd24;
    localparam logic [15:0] RESET_HIGH_WAIT = 16'd180;

    // floor(x / 3) = (x * LUX_RECIP) >> LUX_SHIFT for x below 2**23
    localparam int          LUX_SCALED_BITS = 22;
    localparam logic [21:0] LUX_RECIP       = 22'd2796203;
    localparam int          LUX_SHIFT       = 23;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_time;
        logic [2:0]  first_bus_result;
        logic [2:0]  second_bus_result;
        logic [15:0] read_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  fsm_state_out;
        logic [2:0]  error_cause_out;
        logic        is_ready;
        logic [15:0] raw_out;
        logic [19:0] lux_q4;
        logic [1:0]  cmd_count;
        logic [7:0]  cmd_first;
        logic [7:0]  cmd_second;
        logic        read_issued;
        logic [6:0]  bus_addr_out;
    } t_rsp;

    function automatic logic [2:0] map_bus(input logic [2:0] code);
        logic [2:0] st;
        case (code)
            BR_OK:      st = ST_OK;
            BR_NULL:    st = ST_NULL;
            BR_BUSY:    st = ST_BUSY;
            BR_TIMEOUT: st = ST_TIMEOUT;
            BR_LOCK:    st = ST_BUS;
            default:    st = ST_ERROR;
        endcase
        return st;
    endfunction

endpackage

// ===== rtl/lsms_lux.sv =====
// ----------------------------------------------------------------------------
// lsms_lux: raw sample to lux conversion
// Lux in sixteenths as floor(raw * 40 / 3), divide by reciprocal multiply.
// ----------------------------------------------------------------------------
module lsms_lux (
    input  logic [15:0] i_raw,
    output logic [19:0] o_lux_q4
);

    logic [lsms_pkg::LUX_SCALED_BITS-1:0]   w_scaled;
    logic [2*lsms_pkg::LUX_SCALED_BITS-1:0] w_prod;

    function automatic logic [16:0] raw_pad(input logic [15:0] raw);
        return {1'b0, raw};
    endfunction

    // raw * 40 as raw * 32 + raw * 8
    assign w_scaled = lsms_pkg::LUX_SCALED_BITS'({raw_pad(i_raw), 5'b0})
                    + lsms_pkg::LUX_SCALED_BITS'({raw_pad(i_raw), 3'b0});
    assign w_prod   = (2*lsms_pkg::LUX_SCALED_BITS)'(w_scaled)
                    * (2*lsms_pkg::LUX_SCALED_BITS)'(lsms_pkg::LUX_RECIP);
    assign o_lux_q4 = w_prod[lsms_pkg::LUX_SHIFT +: 20];

endmodule

// ===== rtl/light_sensor_measure_sequencer.sv =====
// ----------------------------------------------------------------------------
// light_sensor_measure_sequencer: one-shot ambient light measurement sequencer
// Flow: a request is held in the request register, then its result in the result register.
// Throughput: one request per cycle while i_out_ready does not stall the output;
// the state update between the request register and the result register is combinational.
// Reset: synchronous active low, machine idle, config and state registers at defaults.
// ----------------------------------------------------------------------------
module light_sensor_measure_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lsms_pkg::t_req       i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lsms_pkg::t_rsp       o_out_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // configuration
    logic [1:0]  r_res_mode;
    logic [6:0]  r_bus_addr;
    logic [15:0] r_low_wait;
    logic [15:0] r_high_wait;

    // request and result stages
    logic             r_in_valid;
    lsms_pkg::t_req   r_in;
    logic             r_out_valid;
    lsms_pkg::t_rsp   r_out;
    lsms_pkg::t_rsp   n_out;
    logic             w_out_load;
    logic             w_fire;

    // machine state
    logic [2:0]                    r_fsm, n_fsm;
    logic [2:0]                    r_last_status, n_last_status;
    logic [2:0]                    r_err_cause, n_err_cause;
    logic [15:0]                   r_raw_sample, n_raw_sample;
    logic [lsms_pkg::TIME_BITS-1:0] r_start_time, n_start_time;
    logic [15:0]                   r_wait_len, n_wait_len;
    logic                          r_start_pending, n_start_pending;
    logic                          r_reset_pending, n_reset_pending;
    logic                          r_data_taken, n_data_taken;

    logic [19:0]                    w_lux;
    logic [lsms_pkg::TIME_BITS-1:0] w_now;
    logic [lsms_pkg::TIME_BITS-1:0] w_elapsed;
    logic [2:0]                     w_r1;
    logic [2:0]                     w_r2;

    assign w_out_load  = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_out_load;
    assign o_in_ready  = !r_in_valid || w_out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_now     = lsms_pkg::TIME_BITS'(r_in.now_time);
    assign w_elapsed = w_now - r_start_time;
    assign w_r1      = lsms_pkg::map_bus(r_in.first_bus_result);
    assign w_r2      = lsms_pkg::map_bus(r_in.second_bus_result);

    lsms_lux u_lux (
        .i_raw    (r_raw_sample),
        .o_lux_q4 (w_lux)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_mode  <= lsms_pkg::RESET_RES_MODE;
            r_bus_addr  <= lsms_pkg::RESET_BUS_ADDR;
            r_low_wait  <= lsms_pkg::RESET_LOW_WAIT;
            r_high_wait <= lsms_pkg::RESET_HIGH_WAIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lsms_pkg::CFG_RES_MODE:  r_res_mode  <= i_cfg_data[1:0];
                lsms_pkg::CFG_BUS_ADDR:  r_bus_addr  <= i_cfg_data[6:0];
                lsms_pkg::CFG_LOW_WAIT:  r_low_wait  <= i_cfg_data;
                lsms_pkg::CFG_HIGH_WAIT: r_high_wait <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [2:0] cur;
        logic [2:0] st;
        logic [1:0] ncmd;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       rdi;
        logic [2:0] status;
        logic [15:0] raw;
        logic [19:0] lux;

        n_fsm           = r_fsm;
        n_last_status   = r_last_status;
        n_err_cause     = r_err_cause;
        n_raw_sample    = r_raw_sample;
        n_start_time    = r_start_time;
        n_wait_len      = r_wait_len;
        n_start_pending = r_start_pending;
        n_reset_pending = r_reset_pending;
        n_data_taken    = r_data_taken;
        cur    = r_fsm;
        st     = lsms_pkg::ST_OK;
        ncmd   = 2'd0;
        c1     = 8'h00;
        c2     = 8'h00;
        rdi    = 1'b0;
        status = lsms_pkg::ST_OK;
        raw    = 16'd0;
        lux    = 20'd0;

        case (r_in.req_type)
            lsms_pkg::REQ_START: begin
                if (r_fsm == lsms_pkg::S_ERROR) begin
                    status = lsms_pkg::ST_ERROR;
                end else if (r_fsm != lsms_pkg::S_IDLE) begin
                    status = lsms_pkg::ST_BUSY;
                end else begin
                    n_start_pending = 1'b1;
                end
            end
            lsms_pkg::REQ_RESET: begin
                n_reset_pending = 1'b1;
            end
            lsms_pkg::REQ_TAKE: begin
                if (r_fsm != lsms_pkg::S_READY) begin
                    status = lsms_pkg::ST_BUSY;
                end else begin
                    raw          = r_raw_sample;
                    lux          = w_lux;
                    n_data_taken = 1'b1;
                end
            end
            default: begin
                if (r_reset_pending && r_fsm != lsms_pkg::S_RESETTING) begin
                    cur             = lsms_pkg::S_RESETTING;
                    n_reset_pending = 1'b0;
                end
                n_fsm = cur;
                case (cur)
                    lsms_pkg::S_IDLE: begin
                        if (r_start_pending) begin
                            n_fsm           = lsms_pkg::S_STARTING;
                            n_start_pending = 1'b0;
                        end
                        n_last_status = lsms_pkg::ST_OK;
                    end
                    lsms_pkg::S_STARTING: begin
                        st   = w_r1;
                        ncmd = 2'd1;
                        c1   = lsms_pkg::CMD_POWER_ON;
                        if (st == lsms_pkg::ST_OK) begin
                            if (r_res_mode == lsms_pkg::RES_LOW) begin
                                c2         = lsms_pkg::CMD_ONCE_LOW;
                                n_wait_len = r_low_wait;
                            end else if (r_res_mode == lsms_pkg::RES_HIGH2) begin
                                c2         = lsms_pkg::CMD_ONCE_HIGH2;
                                n_wait_len = r_high_wait;
                            end else begin
                                c2         = lsms_pkg::CMD_ONCE_HIGH;
                                n_wait_len = r_high_wait;
                            end
                            ncmd = 2'd2;
                            st   = w_r2;
                        end
                        n_last_status = st;
                        if (st == lsms_pkg::ST_OK) begin
                            n_fsm        = lsms_pkg::S_WAITING;
                            n_start_time = w_now;
                        end else if (st != lsms_pkg::ST_BUSY) begin
                            n_fsm         = lsms_pkg::S_ERROR;
                            n_err_cause   = st;
                            n_last_status = lsms_pkg::ST_ERROR;
                        end
                    end
                    lsms_pkg::S_WAITING: begin
                        if (w_elapsed >= lsms_pkg::TIME_BITS'(r_wait_len)) begin
                            n_fsm = lsms_pkg::S_READING;
                        end
                        n_last_status = lsms_pkg::ST_BUSY;
                    end
                    lsms_pkg::S_READING: begin
                        rdi           = 1'b1;
                        n_last_status = w_r1;
                        if (w_r1 == lsms_pkg::ST_OK) begin
                            n_raw_sample = r_in.read_bytes;
                            n_fsm        = lsms_pkg::S_READY;
                        end else if (w_r1 != lsms_pkg::ST_BUSY) begin
                            n_fsm         = lsms_pkg::S_ERROR;
                            n_err_cause   = w_r1;
                            n_last_status = lsms_pkg::ST_ERROR;
                        end
                    end
                    lsms_pkg::S_READY: begin
                        if (r_data_taken) begin
                            n_fsm           = lsms_pkg::S_IDLE;
                            n_last_status   = lsms_pkg::ST_OK;
                            n_err_cause     = lsms_pkg::ST_OK;
                            n_raw_sample    = 16'd0;
                            n_start_time    = '0;
                            n_wait_len      = 16'd0;
                            n_start_pending = 1'b0;
                            n_reset_pending = 1'b0;
                            n_data_taken    = 1'b0;
                        end else begin
                            n_last_status = lsms_pkg::ST_OK;
                        end
                    end
                    lsms_pkg::S_RESETTING: begin
                        st   = w_r1;
                        ncmd = 2'd1;
                        c1   = lsms_pkg::CMD_POWER_ON;
                        if (st == lsms_pkg::ST_OK) begin
                            ncmd = 2'd2;
                            c2   = lsms_pkg::CMD_RESET;
                            st   = w_r2;
                        end
                        n_last_status = st;
                        if (st == lsms_pkg::ST_OK) begin
                            n_fsm           = lsms_pkg::S_IDLE;
                            n_last_status   = lsms_pkg::ST_OK;
                            n_err_cause     = lsms_pkg::ST_OK;
                            n_raw_sample    = 16'd0;
                            n_start_time    = '0;
                            n_wait_len      = 16'd0;
                            n_start_pending = 1'b0;
                            n_reset_pending = 1'b0;
                            n_data_taken    = 1'b0;
                        end else if (st != lsms_pkg::ST_BUSY) begin
                            n_fsm         = lsms_pkg::S_ERROR;
                            n_err_cause   = st;
                            n_last_status = lsms_pkg::ST_ERROR;
                        end
                    end
                    lsms_pkg::S_ERROR: begin
                        n_last_status = lsms_pkg::ST_ERROR;
                    end
                    default: begin
                        n_fsm         = lsms_pkg::S_ERROR;
                        n_err_cause   = lsms_pkg::ST_INVALID;
                        n_last_status = lsms_pkg::ST_ERROR;
                    end
                endcase
                status = n_last_status;
            end
        endcase

        n_out.status          = status;
        n_out.fsm_state_out   = n_fsm;
        n_out.error_cause_out = n_err_cause;
        n_out.is_ready        = (n_fsm == lsms_pkg::S_READY);
        n_out.raw_out         = raw;
        n_out.lux_q4          = lux;
        n_out.cmd_count       = ncmd;
        n_out.cmd_first       = c1;
        n_out.cmd_second      = c2;
        n_out.read_issued     = rdi;
        n_out.bus_addr_out    = (ncmd != 2'd0 || rdi) ? r_bus_addr : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_fsm           <= lsms_pkg::S_IDLE;
            r_last_status   <= lsms_pkg::ST_OK;
            r_err_cause     <= lsms_pkg::ST_OK;
            r_raw_sample    <= 16'd0;
            r_start_time    <= '0;
            r_wait_len      <= 16'd0;
            r_start_pending <= 1'b0;
            r_reset_pending <= 1'b0;
            r_data_taken    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_fsm           <= n_fsm;
                r_last_status   <= n_last_status;
                r_err_cause     <= n_err_cause;
                r_raw_sample    <= n_raw_sample;
                r_start_time    <= n_start_time;
                r_wait_len      <= n_wait_len;
                r_start_pending <= n_start_pending;
                r_reset_pending <= n_reset_pending;
                r_data_taken    <= n_data_taken;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule
